### hdl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is high.
`define ARC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ARC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/arc_pkg.sv
package arc_pkg;

   localparam int CACHE_ENTRIES   = 16;
   localparam int PENDING_ENTRIES = 16;

   localparam logic [31:0] CACHE_LIFE_RESET   = 32'd30000;
   localparam logic [31:0] REQUEST_HOLD_RESET = 32'd5000;

   localparam logic [15:0] ETH_IPV4       = 16'h0800;
   localparam logic [15:0] ETH_ARP        = 16'h0806;
   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
   localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

   localparam logic [1:0] CMD_SEND = 2'd0;
   localparam logic [1:0] CMD_RECV = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   localparam logic [1:0] KIND_IPV4    = 2'd0;
   localparam logic [1:0] KIND_ARP_REQ = 2'd1;
   localparam logic [1:0] KIND_ARP_RSP = 2'd2;
   localparam logic [1:0] KIND_DELIVER = 2'd3;

   localparam logic [1:0] REG_OWN_MAC    = 2'd0;
   localparam logic [1:0] REG_OWN_IP     = 2'd1;
   localparam logic [1:0] REG_CACHE_LIFE = 2'd2;
   localparam logic [1:0] REG_REQ_HOLD   = 2'd3;

   // operation carried by a token along a row of cells
   typedef enum logic [2:0] {
      TOK_FIND,
      TOK_SETDATA,
      TOK_TAKE,
      TOK_INSERT,
      TOK_AGE
   } tok_op_type;

   typedef struct packed {
      logic        active;
      tok_op_type  op;
      logic [31:0] key;
      logic [47:0] data;
      logic [63:0] stamp;
      logic        hit;
      logic [47:0] hdata;
   } token_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEND_C,
      ST_SEND_P,
      ST_SEND_I,
      ST_RX_C,
      ST_RX_I,
      ST_RX_ANSWER,
      ST_RX_P,
      ST_AGE_C,
      ST_AGE_P,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] dst_mac;
      logic [31:0] arp_target_ip;
      logic [47:0] arp_target_mac;
      logic [15:0] tag;
   } result_type;

   typedef struct packed {
      logic [31:0] next_hop_ip;
      logic [15:0] datagram_tag;
      logic [47:0] frame_src_mac;
      logic [15:0] arp_opcode;
      logic [31:0] arp_sender_ip;
      logic [47:0] arp_sender_mac;
      logic [31:0] arp_target_ip;
   } req_type;

endpackage

### hdl/arc_cell.sv
// One table entry; acts on the token passing by, then hands it on.
module arc_cell (
   input  logic                clock,
   input  logic                reset,
   input  arc_pkg::token_type  tok_i,
   output arc_pkg::token_type  tok_o
);

   logic               valid_ff, valid_in;
   logic [31:0]        ip_ff, ip_in;
   logic [47:0]        data_ff, data_in;
   logic [63:0]        stamp_ff, stamp_in;
   arc_pkg::token_type tok_ff, tok_in;
   logic               match;

   assign match = tok_i.active && !tok_i.hit && valid_ff && (ip_ff == tok_i.key);

   always_comb begin
      valid_in = valid_ff;
      ip_in    = ip_ff;
      data_in  = data_ff;
      stamp_in = stamp_ff;
      tok_in   = tok_i;
      if (tok_i.active) begin
         case (tok_i.op)
            arc_pkg::TOK_FIND: begin
               if (match) begin
                  tok_in.hit   = 1'b1;
                  tok_in.hdata = data_ff;
               end
            end
            arc_pkg::TOK_SETDATA: begin
               if (match) begin
                  tok_in.hit = 1'b1;
                  data_in    = tok_i.data;
               end
            end
            arc_pkg::TOK_TAKE: begin
               if (match) begin
                  tok_in.hit   = 1'b1;
                  tok_in.hdata = data_ff;
                  valid_in     = 1'b0;
               end
            end
            arc_pkg::TOK_INSERT: begin
               if (!tok_i.hit && !valid_ff) begin
                  tok_in.hit = 1'b1;
                  valid_in   = 1'b1;
                  ip_in      = tok_i.key;
                  data_in    = tok_i.data;
                  stamp_in   = tok_i.stamp;
               end
            end
            arc_pkg::TOK_AGE: begin
               if (valid_ff && (stamp_ff <= tok_i.stamp)) valid_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
      ip_ff    <= ip_in;
      data_ff  <= data_in;
      stamp_ff <= stamp_in;
   end

   assign tok_o = tok_ff;

endmodule

### hdl/arp_resolution_cache.sv
// ARP resolution cache for one Ethernet/IPv4 port. Requests carry a send, a
// received frame or a time tick; each gives zero or one result (IPv4 frame
// out, ARP request broadcast, ARP reply, or datagram delivered up). The cache
// and the pending table are each a row of 16 cells; an operation walks the
// row as a token, one cell per cycle. A request that is dropped at once or
// needs no table walks no row, a tick ages both rows in turn, and other
// requests take up to three passes: a send miss is cache find, pending
// set-data and pending insert; an ARP reply is cache find, cache insert and
// pending take. One request is worked on at a time; a finished result sits
// in the output register while the next request is taken.
`include "assert_macros.svh"

module arp_resolution_cache (
   input  logic           clock,
   input  logic           reset,
   // request: next_hop_ip, datagram_tag, frame_dst_mac, frame_src_mac,
   // ether_type, parse_ok, arp_opcode, arp_sender_ip, arp_sender_mac,
   // arp_target_ip, elapsed_ms, zero fill
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [327:0]   req_tdata,
   input  logic [1:0]     req_tuser,    // cmd
   // result: out_dst_mac, out_arp_target_ip, out_arp_target_mac, out_tag
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [143:0]   rsp_tdata,
   output logic [1:0]     rsp_tuser,    // out_kind
   input  logic           csr_wen,
   input  logic [1:0]     csr_index,
   input  logic [47:0]    csr_wdata
);

   // request fields
   logic [31:0] f_hop, f_sip, f_tip, f_elapsed;
   logic [15:0] f_tag, f_etype, f_op;
   logic [47:0] f_dst, f_src, f_smac;
   logic        f_ok;

   assign f_hop     = req_tdata[31:0];
   assign f_tag     = req_tdata[47:32];
   assign f_dst     = req_tdata[95:48];
   assign f_src     = req_tdata[143:96];
   assign f_etype   = req_tdata[159:144];
   assign f_ok      = req_tdata[160];
   assign f_op      = req_tdata[176:161];
   assign f_sip     = req_tdata[208:177];
   assign f_smac    = req_tdata[256:209];
   assign f_tip     = req_tdata[288:257];
   assign f_elapsed = req_tdata[320:289];

   // configuration
   logic [47:0] own_mac_ff;
   logic [31:0] own_ip_ff, life_ff, hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         own_ip_ff  <= '0;
         life_ff    <= arc_pkg::CACHE_LIFE_RESET;
         hold_ff    <= arc_pkg::REQUEST_HOLD_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            arc_pkg::REG_OWN_MAC:    own_mac_ff <= csr_wdata;
            arc_pkg::REG_OWN_IP:     own_ip_ff  <= csr_wdata[31:0];
            arc_pkg::REG_CACHE_LIFE: life_ff    <= csr_wdata[31:0];
            arc_pkg::REG_REQ_HOLD:   hold_ff    <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // cell rows
   arc_pkg::token_type ctok [arc_pkg::CACHE_ENTRIES+1];
   arc_pkg::token_type ptok [arc_pkg::PENDING_ENTRIES+1];
   arc_pkg::token_type c_start_ff, c_start_in, p_start_ff, p_start_in;
   arc_pkg::token_type c_end, p_end;

   assign ctok[0] = c_start_ff;
   assign ptok[0] = p_start_ff;
   assign c_end   = ctok[arc_pkg::CACHE_ENTRIES];
   assign p_end   = ptok[arc_pkg::PENDING_ENTRIES];

   for (genvar i = 0; i < arc_pkg::CACHE_ENTRIES; i++) begin : g_cache
      arc_cell u_cell (.clock(clock), .reset(reset), .tok_i(ctok[i]), .tok_o(ctok[i+1]));
   end
   for (genvar i = 0; i < arc_pkg::PENDING_ENTRIES; i++) begin : g_pend
      arc_cell u_cell (.clock(clock), .reset(reset), .tok_i(ptok[i]), .tok_o(ptok[i+1]));
   end

   // control
   arc_pkg::state_type  state_ff, state_in;
   arc_pkg::req_type    req_ff, req_in;
   arc_pkg::result_type res_ff, res_in, rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         now_ff, now_in;
   logic [15:0]         drop_ff, drop_in;
   logic                accept;
   logic                drop;

   assign req_tready = (state_ff == arc_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   function automatic arc_pkg::token_type mk_tok(arc_pkg::tok_op_type op, logic [31:0] key,
                                                  logic [47:0] data, logic [63:0] stamp);
      arc_pkg::token_type t;
      t        = '0;
      t.active = 1'b1;
      t.op     = op;
      t.key    = key;
      t.data   = data;
      t.stamp  = stamp;
      return t;
   endfunction

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      now_in       = now_ff;
      c_start_in   = '0;
      p_start_in   = '0;
      drop         = 1'b0;
      unique case (state_ff)
         arc_pkg::ST_IDLE: begin
            if (accept) begin
               req_in = '{next_hop_ip: f_hop, datagram_tag: f_tag, frame_src_mac: f_src,
                          arp_opcode: f_op, arp_sender_ip: f_sip, arp_sender_mac: f_smac,
                          arp_target_ip: f_tip};
               unique case (req_tuser)
                  arc_pkg::CMD_SEND: begin
                     c_start_in = mk_tok(arc_pkg::TOK_FIND, f_hop, '0, '0);
                     state_in   = arc_pkg::ST_SEND_C;
                  end
                  arc_pkg::CMD_RECV: begin
                     if ((f_dst == own_mac_ff || f_dst == arc_pkg::MAC_BCAST) && f_ok) begin
                        if (f_etype == arc_pkg::ETH_IPV4) begin
                           res_in   = '{kind: arc_pkg::KIND_DELIVER, dst_mac: '0,
                                        arp_target_ip: '0, arp_target_mac: '0, tag: f_tag};
                           state_in = arc_pkg::ST_EMIT;
                        end else if (f_etype == arc_pkg::ETH_ARP) begin
                           c_start_in = mk_tok(arc_pkg::TOK_FIND, f_sip, '0, '0);
                           state_in   = arc_pkg::ST_RX_C;
                        end
                     end
                  end
                  arc_pkg::CMD_TICK: begin
                     now_in     = now_ff + {32'd0, f_elapsed};
                     c_start_in = mk_tok(arc_pkg::TOK_AGE, '0, '0, now_in);
                     state_in   = arc_pkg::ST_AGE_C;
                  end
                  default: ;
               endcase
            end
         end
         arc_pkg::ST_SEND_C: begin
            if (c_end.active) begin
               if (c_end.hit) begin
                  res_in   = '{kind: arc_pkg::KIND_IPV4, dst_mac: c_end.hdata,
                               arp_target_ip: '0, arp_target_mac: '0,
                               tag: req_ff.datagram_tag};
                  state_in = arc_pkg::ST_EMIT;
               end else begin
                  p_start_in = mk_tok(arc_pkg::TOK_SETDATA, req_ff.next_hop_ip,
                                      {32'd0, req_ff.datagram_tag}, '0);
                  state_in   = arc_pkg::ST_SEND_P;
               end
            end
         end
         arc_pkg::ST_SEND_P: begin
            if (p_end.active) begin
               if (p_end.hit) begin
                  state_in = arc_pkg::ST_IDLE;
               end else begin
                  p_start_in = mk_tok(arc_pkg::TOK_INSERT, req_ff.next_hop_ip,
                                      {32'd0, req_ff.datagram_tag},
                                      now_ff + {32'd0, hold_ff});
                  state_in   = arc_pkg::ST_SEND_I;
               end
            end
         end
         arc_pkg::ST_SEND_I: begin
            if (p_end.active) begin
               drop     = !p_end.hit;
               res_in   = '{kind: arc_pkg::KIND_ARP_REQ, dst_mac: arc_pkg::MAC_BCAST,
                            arp_target_ip: req_ff.next_hop_ip, arp_target_mac: '0, tag: '0};
               state_in = arc_pkg::ST_EMIT;
            end
         end
         arc_pkg::ST_RX_C: begin
            if (c_end.active) begin
               if (c_end.hit) begin
                  state_in = arc_pkg::ST_RX_ANSWER;
               end else begin
                  // learn the frame source MAC for an unknown sender
                  c_start_in = mk_tok(arc_pkg::TOK_INSERT, req_ff.arp_sender_ip,
                                      req_ff.frame_src_mac, now_ff + {32'd0, life_ff});
                  state_in   = arc_pkg::ST_RX_I;
               end
            end
         end
         arc_pkg::ST_RX_I: begin
            if (c_end.active) begin
               drop     = !c_end.hit;
               state_in = arc_pkg::ST_RX_ANSWER;
            end
         end
         arc_pkg::ST_RX_ANSWER: begin
            if (req_ff.arp_opcode == arc_pkg::ARP_OP_REQUEST &&
                req_ff.arp_target_ip == own_ip_ff) begin
               res_in   = '{kind: arc_pkg::KIND_ARP_RSP, dst_mac: req_ff.arp_sender_mac,
                            arp_target_ip: req_ff.arp_sender_ip,
                            arp_target_mac: req_ff.arp_sender_mac, tag: '0};
               state_in = arc_pkg::ST_EMIT;
            end else if (req_ff.arp_opcode == arc_pkg::ARP_OP_REPLY) begin
               p_start_in = mk_tok(arc_pkg::TOK_TAKE, req_ff.arp_sender_ip, '0, '0);
               state_in   = arc_pkg::ST_RX_P;
            end else begin
               state_in = arc_pkg::ST_IDLE;
            end
         end
         arc_pkg::ST_RX_P: begin
            if (p_end.active) begin
               if (p_end.hit) begin
                  res_in   = '{kind: arc_pkg::KIND_IPV4, dst_mac: req_ff.arp_sender_mac,
                               arp_target_ip: '0, arp_target_mac: '0,
                               tag: p_end.hdata[15:0]};
                  state_in = arc_pkg::ST_EMIT;
               end else begin
                  state_in = arc_pkg::ST_IDLE;
               end
            end
         end
         arc_pkg::ST_AGE_C: begin
            if (c_end.active) begin
               p_start_in = mk_tok(arc_pkg::TOK_AGE, '0, '0, now_ff);
               state_in   = arc_pkg::ST_AGE_P;
            end
         end
         arc_pkg::ST_AGE_P: begin
            if (p_end.active) state_in = arc_pkg::ST_IDLE;
         end
         arc_pkg::ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = arc_pkg::ST_IDLE;
            end
         end
         default: state_in = arc_pkg::ST_IDLE;
      endcase
      drop_in = (drop && drop_ff != 16'hFFFF) ? drop_ff + 16'd1 : drop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         now_ff       <= '0;
         drop_ff      <= '0;
         c_start_ff   <= '0;
         p_start_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         now_ff       <= now_in;
         drop_ff      <= drop_in;
         c_start_ff   <= c_start_in;
         p_start_ff   <= p_start_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {rsp_ff.tag, rsp_ff.arp_target_mac, rsp_ff.arp_target_ip,
                        rsp_ff.dst_mac};

   `ARC_ASSERT(a_one_row_at_a_time, clock, reset, !(c_start_ff.active && p_start_ff.active), "both rows started together")
   `ARC_ASSERT(a_no_pass_when_idle, clock, reset, (state_ff == arc_pkg::ST_IDLE) |-> !(c_end.active || p_end.active), "pass finished while idle")
   `ARC_ASSERT(a_bcast_dst, clock, reset, (rsp_valid_ff && rsp_ff.kind == arc_pkg::KIND_ARP_REQ) |-> (rsp_ff.dst_mac == arc_pkg::MAC_BCAST), "ARP request not broadcast")

endmodule

### dv/tb_arp_resolution_cache.sv
module tb_arp_resolution_cache;

   // one event for the cache
   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] next_hop_ip;
      logic [15:0] datagram_tag;
      logic [47:0] frame_dst_mac;
      logic [47:0] frame_src_mac;
      logic [15:0] ether_type;
      logic        parse_ok;
      logic [15:0] arp_opcode;
      logic [31:0] arp_sender_ip;
      logic [47:0] arp_sender_mac;
      logic [31:0] arp_target_ip;
      logic [31:0] elapsed_ms;
   } arp_event_type;

   typedef struct {
      logic [1:0]  kind;
      logic [47:0] dst_mac;
      logic [31:0] target_ip;
      logic [47:0] target_mac;
      logic [15:0] tag;
   } arp_out_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   // next_hop_ip, datagram_tag, frame_dst_mac, frame_src_mac, ether_type,
   // parse_ok, arp_opcode, arp_sender_ip, arp_sender_mac, arp_target_ip,
   // elapsed_ms, zero fill
   logic [327:0]   req_tdata = '0;
   logic [1:0]     req_tuser = '0;    // cmd
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   // out_dst_mac, out_arp_target_ip, out_arp_target_mac, out_tag
   logic [143:0]   rsp_tdata;
   logic [1:0]     rsp_tuser;         // out_kind
   logic           csr_wen = 1'b0;
   logic [1:0]     csr_index = '0;
   logic [47:0]    csr_wdata = '0;

   arp_resolution_cache DUT (.*);

   always #6 clock = ~clock;

   // ---- shadow copy of the cache state ----
   logic [47:0] m_own_mac;
   logic [31:0] m_own_ip, m_life, m_hold;
   logic        c_vld [arc_pkg::CACHE_ENTRIES];
   logic [31:0] c_ip  [arc_pkg::CACHE_ENTRIES];
   logic [47:0] c_mac [arc_pkg::CACHE_ENTRIES];
   logic [63:0] c_exp [arc_pkg::CACHE_ENTRIES];
   logic        p_vld [arc_pkg::PENDING_ENTRIES];
   logic [31:0] p_ip  [arc_pkg::PENDING_ENTRIES];
   logic [15:0] p_tag [arc_pkg::PENDING_ENTRIES];
   logic [63:0] p_dl  [arc_pkg::PENDING_ENTRIES];
   logic [63:0] m_now;

   arp_event_type pending_requests[$];
   arp_out_type   expected_frames[$];
   int            errors = 0;
   int            checked = 0;
   int            sent = 0;
   int            n_kind[4] = '{0, 0, 0, 0};
   longint        cycles = 0;

   function automatic arp_out_type mk_out(logic [1:0] k, logic [47:0] d, logic [31:0] ip,
                                          logic [47:0] m, logic [15:0] t);
      arp_out_type o;
      o.kind = k; o.dst_mac = d; o.target_ip = ip; o.target_mac = m; o.tag = t;
      return o;
   endfunction

   // Apply one event to the shadow state, queue the frame it should produce.
   task automatic resolve_event(arp_event_type e);
      int c, p, f;
      c = -1; p = -1; f = -1;
      case (e.cmd)
         arc_pkg::CMD_SEND: begin
            for (int i = arc_pkg::CACHE_ENTRIES - 1; i >= 0; i--)
               if (c_vld[i] && c_ip[i] == e.next_hop_ip) c = i;
            if (c >= 0) begin
               expected_frames.push_back(mk_out(arc_pkg::KIND_IPV4, c_mac[c], '0, '0,
                                                e.datagram_tag));
               return;
            end
            for (int i = arc_pkg::PENDING_ENTRIES - 1; i >= 0; i--) begin
               if (p_vld[i] && p_ip[i] == e.next_hop_ip) p = i;
               if (!p_vld[i]) f = i;
            end
            if (p >= 0) begin
               // repeated send: newest tag wins, deadline kept, nothing emitted
               p_tag[p] = e.datagram_tag;
               return;
            end
            if (f >= 0) begin
               p_vld[f] = 1; p_ip[f] = e.next_hop_ip; p_tag[f] = e.datagram_tag;
               p_dl[f] = m_now + m_hold;
            end
            expected_frames.push_back(mk_out(arc_pkg::KIND_ARP_REQ, arc_pkg::MAC_BCAST,
                                             e.next_hop_ip, '0, '0));
         end
         arc_pkg::CMD_RECV: begin
            if (e.frame_dst_mac != m_own_mac && e.frame_dst_mac != arc_pkg::MAC_BCAST) return;
            if (!e.parse_ok) return;
            if (e.ether_type == arc_pkg::ETH_IPV4) begin
               expected_frames.push_back(mk_out(arc_pkg::KIND_DELIVER, '0, '0, '0,
                                                e.datagram_tag));
               return;
            end
            if (e.ether_type != arc_pkg::ETH_ARP) return;
            for (int i = arc_pkg::CACHE_ENTRIES - 1; i >= 0; i--) begin
               if (c_vld[i] && c_ip[i] == e.arp_sender_ip) c = i;
               if (!c_vld[i]) f = i;
            end
            // learn from the frame source MAC, never refresh a known sender
            if (c < 0 && f >= 0) begin
               c_vld[f] = 1; c_ip[f] = e.arp_sender_ip; c_mac[f] = e.frame_src_mac;
               c_exp[f] = m_now + m_life;
            end
            if (e.arp_opcode == arc_pkg::ARP_OP_REQUEST && e.arp_target_ip == m_own_ip) begin
               expected_frames.push_back(mk_out(arc_pkg::KIND_ARP_RSP, e.arp_sender_mac,
                                                e.arp_sender_ip, e.arp_sender_mac, '0));
               return;
            end
            if (e.arp_opcode == arc_pkg::ARP_OP_REPLY) begin
               for (int i = arc_pkg::PENDING_ENTRIES - 1; i >= 0; i--)
                  if (p_vld[i] && p_ip[i] == e.arp_sender_ip) p = i;
               if (p >= 0) begin
                  p_vld[p] = 0;
                  expected_frames.push_back(mk_out(arc_pkg::KIND_IPV4, e.arp_sender_mac,
                                                   '0, '0, p_tag[p]));
               end
            end
         end
         arc_pkg::CMD_TICK: begin
            m_now = m_now + e.elapsed_ms;
            for (int i = 0; i < arc_pkg::CACHE_ENTRIES; i++)
               if (c_vld[i] && c_exp[i] <= m_now) c_vld[i] = 0;
            for (int i = 0; i < arc_pkg::PENDING_ENTRIES; i++)
               if (p_vld[i] && p_dl[i] <= m_now) p_vld[i] = 0;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch #%0d at cycle %0d: %s got %h want %h", errors, cycles, what,
               got, want);
   endtask

   // ---- driver: bursts of requests with random gaps ----
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      arp_event_type e;
      logic          load;
      if (!reset) begin
         load = 0;
         if (req_tvalid && req_tready) begin
            resolve_event(pending_requests.pop_front());
            sent++;
            load = 1;
         end else if (!req_tvalid)
            load = 1;
         if (load) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0)
               req_tvalid <= 1'b0;
            else begin
               e = pending_requests[0];
               req_tvalid <= 1'b1;
               req_tuser  <= e.cmd;
               req_tdata  <= {7'd0, e.elapsed_ms, e.arp_target_ip, e.arp_sender_mac,
                              e.arp_sender_ip, e.arp_opcode, e.parse_ok, e.ether_type,
                              e.frame_src_mac, e.frame_dst_mac, e.datagram_tag,
                              e.next_hop_ip};
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
               end
            end
         end
      end
   end

   // ---- monitor: receiver stall pattern plus checks ----
   int stall_phase = 0;
   always @(posedge clock) begin
      arp_out_type want;
      cycles++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_frames.size() == 0)
               report_mismatch("unexpected result kind", rsp_tuser, 0);
            else begin
               want = expected_frames.pop_front();
               n_kind[want.kind]++;
               if (rsp_tuser !== want.kind) report_mismatch("out_kind", rsp_tuser, want.kind);
               if (rsp_tdata[47:0] !== want.dst_mac)
                  report_mismatch("out_dst_mac", rsp_tdata[47:0], want.dst_mac);
               if (rsp_tdata[79:48] !== want.target_ip)
                  report_mismatch("out_arp_target_ip", rsp_tdata[79:48], want.target_ip);
               if (rsp_tdata[127:80] !== want.target_mac)
                  report_mismatch("out_arp_target_mac", rsp_tdata[127:80], want.target_mac);
               if (rsp_tdata[143:128] !== want.tag)
                  report_mismatch("out_tag", rsp_tdata[143:128], want.tag);
            end
         end
         // stall in stretches: long clean runs, then choppy ones
         stall_phase = (stall_phase + 1) % 256;
         rsp_tready <= (stall_phase < 96) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
      if (cycles > 2_000_000) begin
         $display("timeout at cycle %0d, %0d results still owed", cycles,
                  expected_frames.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---- stimulus ----
   logic [31:0] ip_pool [8];
   logic [47:0] mac_pool [4];

   function automatic arp_event_type blank_event(logic [1:0] cmd);
      arp_event_type e;
      e = '{cmd: cmd, ether_type: arc_pkg::ETH_ARP, parse_ok: 1'b1,
            arp_opcode: arc_pkg::ARP_OP_REPLY, frame_dst_mac: arc_pkg::MAC_BCAST,
            default: '0};
      return e;
   endfunction

   function automatic arp_event_type send_event(logic [31:0] ip, logic [15:0] tag);
      arp_event_type e;
      e = blank_event(arc_pkg::CMD_SEND);
      e.next_hop_ip = ip; e.datagram_tag = tag;
      return e;
   endfunction

   function automatic arp_event_type arp_event(logic [15:0] op, logic [31:0] sip,
                                               logic [47:0] smac, logic [31:0] tip);
      arp_event_type e;
      e = blank_event(arc_pkg::CMD_RECV);
      e.arp_opcode = op; e.arp_sender_ip = sip; e.arp_sender_mac = smac;
      e.frame_src_mac = 48'({$urandom, $urandom}); e.arp_target_ip = tip;
      e.datagram_tag = 16'($urandom);
      return e;
   endfunction

   function automatic arp_event_type tick_event(logic [31:0] ms);
      arp_event_type e;
      e = blank_event(arc_pkg::CMD_TICK);
      e.elapsed_ms = ms;
      return e;
   endfunction

   // random event, mostly drawn from a small address pool so hits happen
   function automatic arp_event_type random_event();
      arp_event_type e;
      int            r;
      r = $urandom_range(0, 99);
      if (r < 35)
         e = send_event(ip_pool[$urandom_range(0, 7)], 16'($urandom));
      else if (r < 70) begin
         e = arp_event($urandom_range(0, 1) ? arc_pkg::ARP_OP_REPLY : arc_pkg::ARP_OP_REQUEST,
                       ip_pool[$urandom_range(0, 7)], mac_pool[$urandom_range(0, 3)],
                       $urandom_range(0, 1) ? m_own_ip : $urandom);
         e.frame_dst_mac = $urandom_range(0, 1) ? arc_pkg::MAC_BCAST : m_own_mac;
      end else if (r < 80)
         e = tick_event($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8000));
      else if (r < 88) begin
         e = arp_event(arc_pkg::ARP_OP_REQUEST, $urandom, 48'({$urandom, $urandom}),
                       $urandom);
         e.frame_dst_mac = m_own_mac;
         e.ether_type = arc_pkg::ETH_IPV4;
      end else begin
         // noise: every field random, unknown command included
         e.cmd = 2'($urandom); e.next_hop_ip = $urandom; e.datagram_tag = 16'($urandom);
         e.frame_dst_mac = 48'({$urandom, $urandom});
         e.frame_src_mac = 48'({$urandom, $urandom});
         e.ether_type = $urandom_range(0, 1) ? arc_pkg::ETH_ARP : 16'($urandom);
         e.parse_ok = 1'($urandom); e.arp_opcode = 16'($urandom);
         e.arp_sender_ip = $urandom; e.arp_sender_mac = 48'({$urandom, $urandom});
         e.arp_target_ip = $urandom; e.elapsed_ms = $urandom;
      end
      return e;
   endfunction

   task automatic drain_and_wait();
      while (pending_requests.size() != 0 || req_tvalid || expected_frames.size() != 0)
         @(posedge clock);
      // a request with no result may still be walking the tables
      repeat (80) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [47:0] val);
      @(posedge clock);
      csr_wen <= 1'b1; csr_index <= idx; csr_wdata <= val;
      case (idx)
         arc_pkg::REG_OWN_MAC:    m_own_mac = val;
         arc_pkg::REG_OWN_IP:     m_own_ip  = val[31:0];
         arc_pkg::REG_CACHE_LIFE: m_life    = val[31:0];
         default:                 m_hold    = val[31:0];
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      arp_event_type e;
      m_own_mac = '0; m_own_ip = '0;
      m_life = arc_pkg::CACHE_LIFE_RESET; m_hold = arc_pkg::REQUEST_HOLD_RESET;
      m_now = '0;
      foreach (c_vld[i]) c_vld[i] = 0;
      foreach (p_vld[i]) p_vld[i] = 0;
      foreach (ip_pool[i]) ip_pool[i] = $urandom;
      ip_pool[0] = 32'hFFFF_FFFF; ip_pool[1] = 32'h0;
      foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_register(arc_pkg::REG_OWN_MAC, 48'h0200_0000_0001);
      write_register(arc_pkg::REG_OWN_IP, 48'h0000_C0A8_0001);

      // directed: miss, repeat miss, reply releases, hit, request for us, delivery
      pending_requests.push_back(send_event(32'h0A00_0001, 16'hFFFF));
      pending_requests.push_back(send_event(32'h0A00_0001, 16'h1234));
      pending_requests.push_back(arp_event(arc_pkg::ARP_OP_REPLY, 32'h0A00_0001,
                                           48'hFFFF_FFFF_FFFE, '0));
      pending_requests.push_back(send_event(32'h0A00_0001, 16'h0));
      pending_requests.push_back(arp_event(arc_pkg::ARP_OP_REQUEST, 32'hFFFF_FFFF, 48'h0,
                                           32'hC0A8_0001));
      pending_requests.push_back(arp_event(arc_pkg::ARP_OP_REQUEST, 32'h0A00_0002, 48'h1,
                                           32'hC0A8_0002));
      pending_requests.push_back(arp_event(16'hFFFF, 32'h0A00_0003, 48'h2, '0));
      pending_requests.push_back(arp_event(arc_pkg::ARP_OP_REPLY, 32'h0B00_0000, 48'h3, '0));
      e = arp_event(arc_pkg::ARP_OP_REPLY, 32'h0A00_0004, 48'h4, '0);
      e.ether_type = arc_pkg::ETH_IPV4; e.frame_dst_mac = 48'h0200_0000_0001;
      pending_requests.push_back(e);
      e.parse_ok = 0;                       // parse failure dropped
      pending_requests.push_back(e);
      e.parse_ok = 1; e.frame_dst_mac = 48'h0200_0000_0002;   // not for us
      pending_requests.push_back(e);
      e.frame_dst_mac = arc_pkg::MAC_BCAST; e.ether_type = 16'h86DD;   // other type
      pending_requests.push_back(e);
      e.cmd = 2'd3;                          // unknown command
      pending_requests.push_back(e);
      // fill the pending table past full, then expire everything
      for (int i = 0; i < arc_pkg::PENDING_ENTRIES + 2; i++)
         pending_requests.push_back(send_event(32'h1400_0000 + i, 16'(i)));
      pending_requests.push_back(tick_event(32'hFFFF_FFFF));
      drain_and_wait();

      // full cache, short lifetimes
      write_register(arc_pkg::REG_CACHE_LIFE, 48'd1);
      write_register(arc_pkg::REG_REQ_HOLD, 48'h0000_FFFF_FFFF);
      for (int i = 0; i < arc_pkg::CACHE_ENTRIES + 2; i++)
         pending_requests.push_back(arp_event(arc_pkg::ARP_OP_REPLY, 32'h1E00_0000 + i,
                                              48'(i), '0));
      pending_requests.push_back(send_event(32'h1E00_0011, 16'hABCD));
      pending_requests.push_back(tick_event(32'd0));
      pending_requests.push_back(tick_event(32'd1));
      pending_requests.push_back(send_event(32'h1E00_0000, 16'h5555));
      drain_and_wait();

      // random phases across register settings
      for (int ph = 0; ph < 4; ph++) begin
         write_register(arc_pkg::REG_OWN_MAC,
                        ph == 3 ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}));
         write_register(arc_pkg::REG_OWN_IP,
                        ph == 2 ? 48'h0 : {16'h0, ip_pool[$urandom_range(2, 7)]});
         write_register(arc_pkg::REG_CACHE_LIFE,
                        ph == 1 ? 48'h0000_FFFF_FFFF : 48'($urandom_range(1, 20000)));
         write_register(arc_pkg::REG_REQ_HOLD,
                        ph == 1 ? 48'd1 : 48'($urandom_range(1, 10000)));
         for (int i = 0; i < 170; i++)
            pending_requests.push_back(random_event());
         drain_and_wait();
      end

      $display("ran %0d requests, %0d results: %0d ipv4, %0d arp req, %0d arp rsp, %0d up",
               sent, checked, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
      if (errors == 0 && expected_frames.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
